[sv/plm_pkg.sv]
`default_nettype none

package plm_pkg;

    // table depth and register map
    localparam int PLM_TABLE_DEPTH = 128;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_X_PHS  = 3'd1;
    localparam logic [2:0] REG_X_FREQ = 3'd2;
    localparam logic [2:0] REG_X_AMP  = 3'd3;
    localparam logic [2:0] REG_Y_PHS  = 3'd4;
    localparam logic [2:0] REG_Y_FREQ = 3'd5;
    localparam logic [2:0] REG_Y_AMP  = 3'd6;

    // mode_flags bit positions
    localparam int FLAG_ALPHA  = 0;
    localparam int FLAG_SCALE  = 1;
    localparam int FLAG_COSINE = 2;
    localparam int FLAG_SAW    = 3;
    localparam int FLAG_SQUARE = 4;
    localparam int FLAG_SEP_Y  = 5;
    localparam int FLAG_RAND_X = 6;
    localparam int FLAG_RAND_Y = 7;

    localparam logic [15:0] FREQ_RESET = 16'd256;
    localparam logic [15:0] AMP_RESET  = 16'd16384;
    localparam logic signed [18:0] UNITY_Q16 = 19'sd65536;

    // index accumulator: age*freq<<8 + phase*freq + N*rnd fits 49 bits,
    // the whole-step part from bit 16 up is 33 bits, reduced 11 bits per digit
    localparam int ACC_W  = 49;
    localparam int V_W    = 33;
    localparam int DIG_W  = 11;
    localparam int NDIG   = 3;
    localparam int REC_SH = 31;
    localparam int REC_W  = 28;

    // multiply, add, two stages per digit, wave, amplitude, final
    localparam int PLM_CH_STAGES = 5 + 2 * NDIG;

    typedef struct packed {
        logic square;
        logic saw;
        logic cosine;
    } plm_wave_ctl_t;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // cos(r * pi/2), r in Q0.30 of a quarter turn, result Q30 (nested Taylor)
    function automatic logic signed [63:0] plm_quarter_cos(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 132;
        t  = Q30_ONE - ((x2 * t) >> 30) / 90;
        t  = Q30_ONE - ((x2 * t) >> 30) / 56;
        t  = Q30_ONE - ((x2 * t) >> 30) / 30;
        t  = Q30_ONE - ((x2 * t) >> 30) / 12;
        return $signed(Q30_ONE) - $signed(((x2 * t) >> 30) / 2);
    endfunction

    // raised cosine in Q1.15 from a 32-bit phase (one turn = 2^32)
    function automatic logic [15:0] plm_cos_wave(input logic [63:0] p);
        logic [1:0]         q;
        logic [63:0]        r;
        logic signed [63:0] c;
        logic signed [63:0] v;
        logic [63:0]        w;
        q = p[31:30];
        r = p & (Q30_ONE - 64'd1);
        unique case (q)
            2'd0: c = plm_quarter_cos(r);
            2'd1: c = -plm_quarter_cos(Q30_ONE - r);
            2'd2: c = -plm_quarter_cos(r);
            2'd3: c = plm_quarter_cos(Q30_ONE - r);
        endcase
        v = $signed(Q30_ONE) + c;
        if (v < 0)
        begin
            v = 64'sd0;
        end
        w = ($unsigned(v) + 64'd32768) >> 16;
        if (w > 64'd32768)
        begin
            w = 64'd32768;
        end
        return w[15:0];
    endfunction

endpackage

`default_nettype wire

[sv/plm_channel.sv]
`default_nettype none

module plm_channel
    import plm_pkg::*;
#(
    parameter int TABLE_DEPTH = PLM_TABLE_DEPTH
)
(
    input  wire logic                       clk,
    input  wire logic [PLM_CH_STAGES-1:0]   stage_en,
    input  wire logic [23:0]                age,
    input  wire logic [15:0]                rnd,
    input  wire logic                       use_rand,
    input  wire logic [23:0]                phase,
    input  wire logic [15:0]                freq,
    input  wire logic [15:0]                amp,
    input  wire plm_wave_ctl_t              wave_ctl,
    output logic signed [18:0]              result
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int TW = IW + DIG_W;
    localparam int PW = TW + REC_W;
    localparam int QW = PW - REC_SH;
    localparam logic [TW-1:0]    NV    = TW'(TABLE_DEPTH);
    localparam logic [10:0]      NR    = 11'(TABLE_DEPTH);
    localparam logic [REC_W-1:0] RECIP = REC_W'((64'd1 << REC_SH) / TABLE_DEPTH);
    localparam int HALF = TABLE_DEPTH / 2;
    localparam int ST_WAVE = 2 + 2 * NDIG;
    localparam int ST_AMP  = ST_WAVE + 1;
    localparam int ST_FIN  = ST_WAVE + 2;

    // waveform tables, built at elaboration
    logic [15:0] cos_tab [TABLE_DEPTH];
    logic [15:0] saw_tab [TABLE_DEPTH];

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_tab
        localparam logic [63:0] PH  = (64'(i) << 32) / TABLE_DEPTH;
        localparam logic [15:0] SAW = 16'(((64'(i) << 15) + 64'(HALF)) / TABLE_DEPTH);
        assign cos_tab[i] = plm_cos_wave(PH);
        assign saw_tab[i] = SAW;
    end

    // stage 0: products
    logic [39:0] p_age_reg;
    logic [39:0] p_ph_reg;
    logic [15:0] rnd_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            p_age_reg <= 40'(age) * 40'(freq);
            p_ph_reg  <= 40'(phase) * 40'(freq);
            rnd_reg   <= use_rand ? rnd : 16'd0;
        end
    end

    // stage 1: accumulate, keep the whole table steps
    logic [ACC_W-1:0] acc;
    logic [V_W-1:0]   v_reg;

    assign acc = ACC_W'({p_age_reg, 8'd0}) + ACC_W'(p_ph_reg)
               + ACC_W'(27'(rnd_reg) * 27'(NR));

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            v_reg <= acc[ACC_W-1:ACC_W-V_W];
        end
    end

    // mod N, one 11-bit digit per pair of stages: estimate quotient by
    // reciprocal, then subtract q*N with one correction step
    logic [TW-1:0]  ta_reg [NDIG];
    logic [PW-1:0]  pa_reg [NDIG];
    logic [V_W-1:0] va_reg [NDIG];
    logic [V_W-1:0] vb_reg [NDIG];
    logic [IW-1:0]  r_reg  [NDIG];

    for (genvar k = 0; k < NDIG; k++)
    begin : g_dig
        logic [V_W-1:0] v_prev;
        logic [TW-1:0]  t_in;
        logic [QW-1:0]  q;
        logic [TW-1:0]  qn;
        logic [TW-1:0]  rem;
        logic [TW-1:0]  rem_fix;

        if (k == 0)
        begin : g_first
            assign v_prev = v_reg;
            assign t_in   = TW'(v_reg[V_W-1 -: DIG_W]);
        end
        else
        begin : g_next
            assign v_prev = vb_reg[k-1];
            assign t_in   = {r_reg[k-1], vb_reg[k-1][V_W-1-k*DIG_W -: DIG_W]};
        end

        assign q       = pa_reg[k][PW-1:REC_SH];
        assign qn      = TW'(TW'(q) * NV);
        assign rem     = ta_reg[k] - qn;
        assign rem_fix = (rem >= NV) ? rem - NV : rem;

        always_ff @(posedge clk)
        begin
            if (stage_en[2+2*k])
            begin
                ta_reg[k] <= t_in;
                pa_reg[k] <= PW'(t_in) * PW'(RECIP);
                va_reg[k] <= v_prev;
            end
            if (stage_en[3+2*k])
            begin
                r_reg[k]  <= rem_fix[IW-1:0];
                vb_reg[k] <= va_reg[k];
            end
        end
    end

    // wave select: square over saw over cosine
    logic [IW-1:0] idx;
    logic [15:0]   wave_next;
    logic          none_next;
    logic [15:0]   wave_reg;
    logic          none_w_reg;

    assign idx = r_reg[NDIG-1];

    always_comb
    begin
        wave_next = 16'd0;
        none_next = 1'b0;
        priority if (wave_ctl.square)
        begin
            wave_next = (32'(idx) < 32'(HALF)) ? 16'd32768 : 16'd0;
        end
        else if (wave_ctl.saw)
        begin
            wave_next = saw_tab[idx];
        end
        else if (wave_ctl.cosine)
        begin
            wave_next = cos_tab[idx];
        end
        else
        begin
            none_next = 1'b1;
        end
    end

    logic [31:0] prod_reg;
    logic        none_m_reg;
    logic [31:0] prod_rnd;
    logic signed [18:0] res_reg;

    assign prod_rnd = prod_reg + 32'd4096;

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_WAVE])
        begin
            wave_reg   <= wave_next;
            none_w_reg <= none_next;
        end
        if (stage_en[ST_AMP])
        begin
            prod_reg   <= 32'(wave_reg) * 32'(amp);
            none_m_reg <= none_w_reg;
        end
        if (stage_en[ST_FIN])
        begin
            res_reg <= none_m_reg ? UNITY_Q16
                                  : UNITY_Q16 - $signed(prod_rnd[31:13]);
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

[sv/particle_lfo_modulator.sv]
// Throughput: one item per cycle while m_axis_tready is high; the 12-stage
// pipeline collapses bubbles, and while m_axis_tready is low a stage holds
// only when it and every stage after it hold an item.
// Reset (rst_n, async, active low) clears the stage valid bits and loads
// the register defaults; config writes are taken every cycle.
`default_nettype none

module particle_lfo_modulator
    import plm_pkg::*;
#(
    parameter int TABLE_DEPTH = PLM_TABLE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // particle_age[23:0], random_fraction[39:24]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // alpha_value[18:0], scale_x_value[37:19],
                                             // scale_y_value[56:38], zero[63:57]
    output logic [1:0]       m_axis_tuser,   // alpha_write[0], scale_write[1]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int NS = PLM_CH_STAGES + 1;

    // configuration registers
    logic [7:0]  mode_reg;
    logic [23:0] x_phase_reg;
    logic [15:0] x_freq_reg;
    logic [15:0] x_amp_reg;
    logic [23:0] y_phase_reg;
    logic [15:0] y_freq_reg;
    logic [15:0] y_amp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 8'd0;
            x_phase_reg <= 24'd0;
            x_freq_reg  <= FREQ_RESET;
            x_amp_reg   <= AMP_RESET;
            y_phase_reg <= 24'd0;
            y_freq_reg  <= FREQ_RESET;
            y_amp_reg   <= AMP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg    <= cfg_data[7:0];
                REG_X_PHS:  x_phase_reg <= cfg_data;
                REG_X_FREQ: x_freq_reg  <= cfg_data[15:0];
                REG_X_AMP:  x_amp_reg   <= cfg_data[15:0];
                REG_Y_PHS:  y_phase_reg <= cfg_data;
                REG_Y_FREQ: y_freq_reg  <= cfg_data[15:0];
                REG_Y_AMP:  y_amp_reg   <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    // pipeline control: a stage loads when empty or when the next one moves
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] stage_en;

    always_comb
    begin
        stage_en[NS-1] = !valid_reg[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_axis_tready = stage_en[0];

    plm_wave_ctl_t wave_ctl;
    assign wave_ctl.square = mode_reg[FLAG_SQUARE];
    assign wave_ctl.saw    = mode_reg[FLAG_SAW];
    assign wave_ctl.cosine = mode_reg[FLAG_COSINE];

    logic signed [18:0] fx;
    logic signed [18:0] fy;

    plm_channel #(.TABLE_DEPTH(TABLE_DEPTH)) u_chan_x (
        .clk      (clk),
        .stage_en (stage_en[PLM_CH_STAGES-1:0]),
        .age      (s_axis_tdata[23:0]),
        .rnd      (s_axis_tdata[39:24]),
        .use_rand (mode_reg[FLAG_RAND_X]),
        .phase    (x_phase_reg),
        .freq     (x_freq_reg),
        .amp      (x_amp_reg),
        .wave_ctl (wave_ctl),
        .result   (fx)
    );

    plm_channel #(.TABLE_DEPTH(TABLE_DEPTH)) u_chan_y (
        .clk      (clk),
        .stage_en (stage_en[PLM_CH_STAGES-1:0]),
        .age      (s_axis_tdata[23:0]),
        .rnd      (s_axis_tdata[39:24]),
        .use_rand (mode_reg[FLAG_RAND_Y]),
        .phase    (y_phase_reg),
        .freq     (y_freq_reg),
        .amp      (y_amp_reg),
        .wave_ctl (wave_ctl),
        .result   (fy)
    );

    // output stage
    logic signed [18:0] alpha_reg;
    logic signed [18:0] sx_reg;
    logic signed [18:0] sy_reg;
    logic               aw_reg;
    logic               sw_reg;
    logic               wa;
    logic               ws;
    logic signed [18:0] fy_sel;

    assign wa     = mode_reg[FLAG_ALPHA];
    assign ws     = mode_reg[FLAG_SCALE];
    assign fy_sel = mode_reg[FLAG_SEP_Y] ? fy : fx;

    always_ff @(posedge clk)
    begin
        if (stage_en[NS-1])
        begin
            alpha_reg <= wa ? fx : UNITY_Q16;
            sx_reg    <= ws ? fx : UNITY_Q16;
            sy_reg    <= ws ? fy_sel : UNITY_Q16;
            aw_reg    <= wa;
            sw_reg    <= ws;
        end
    end

    assign m_axis_tvalid = valid_reg[NS-1];
    assign m_axis_tdata  = {7'd0, sy_reg, sx_reg, alpha_reg};
    assign m_axis_tuser  = {sw_reg, aw_reg};

    // input side only stalls when every stage holds an item
    a_full_when_stalled: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (valid_reg == {NS{1'b1}}))
        else $error("input stalled with an empty stage");

    a_alpha_neutral: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !mode_reg[FLAG_ALPHA]) |->
            (m_axis_tdata[18:0] == UNITY_Q16 && !m_axis_tuser[0]))
        else $error("alpha not neutral with alpha write off");

    a_scale_neutral: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !mode_reg[FLAG_SCALE]) |->
            (m_axis_tdata[37:19] == UNITY_Q16 && m_axis_tdata[56:38] == UNITY_Q16))
        else $error("scale not neutral with scale write off");

    a_y_copies_x: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !mode_reg[FLAG_SEP_Y]) |->
            (m_axis_tdata[56:38] == m_axis_tdata[37:19]))
        else $error("scale y differs from x without separate y");

endmodule

`default_nettype wire
